/* rtl/pscfg_pkg.sv */
// ----------------------------------------------------------------------------
// pscfg_pkg: shared types and constants for the flood guard
// Register indexes, verdict codes, entry and configuration record types and field widths.
// ----------------------------------------------------------------------------
package pscfg_pkg;

    localparam int TIME_W  = 48;
    localparam int ADDR_W  = 64;
    localparam int SPAN_W  = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_GUARD_ENABLE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FIRST_SPAN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPAN_CAP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_ENTRY_LIFETIME = 3'd3;
    localparam logic [IDX_W-1:0] REG_REPEAT_LIMIT   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SWEEP_INTERVAL = 3'd5;
    localparam logic [IDX_W-1:0] REG_PER_ADDR_LIMIT = 3'd6;
    localparam logic [IDX_W-1:0] REG_UNEST_LIMIT    = 3'd7;

    localparam logic [2:0] VERDICT_ADMIT   = 3'd0;
    localparam logic [2:0] VERDICT_REPEAT  = 3'd1;
    localparam logic [2:0] VERDICT_NO_SSL  = 3'd2;
    localparam logic [2:0] VERDICT_PER_ADR = 3'd3;
    localparam logic [2:0] VERDICT_UNEST   = 3'd4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int ENTRY_W = 2*ADDR_W + 2*TIME_W + SPAN_W + COUNT_W;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr_high;
        logic [ADDR_W-1:0]  addr_low;
        logic [TIME_W-1:0]  last_seen;
        logic [SPAN_W-1:0]  span;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  delete_at;
    } entry_t;

    // configuration snapshot handed to the sequencer
    typedef struct packed {
        logic               guard_enable;
        logic [SPAN_W-1:0]  first_span;
        logic [SPAN_W-1:0]  span_cap;
        logic [SPAN_W-1:0]  entry_lifetime;
        logic [COUNT_W-1:0] repeat_limit;
        logic [SPAN_W-1:0]  sweep_interval;
        logic [COUNT_W-1:0] per_address_limit;
        logic [COUNT_W-1:0] unestablished_limit;
    } cfg_t;

endpackage

/* rtl/per_source_connection_flood_guard.sv */
// ----------------------------------------------------------------------------
// per_source_connection_flood_guard: per-source connection admission guard
// Flow: accept, sweep of every entry when one is due, lookup search, update,
//   entry write (on a hit or a new slot) and checks (a remove skips both), then
//   result; an add item with the guard off or bypassed goes straight to the result.
// Throughput: one item at a time; a new item is accepted in the cycle after
//   the result is taken. Each table step reads one entry through the single RAM
//   port, passing the read, compare and act states for each entry.
// Reset: synchronous active-low; valid bits cleared, registers to defaults.
// ----------------------------------------------------------------------------
module per_source_connection_flood_guard #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [63:0] s_addr_high,
    input  logic [63:0] s_addr_low,
    input  logic [47:0] s_now,
    input  logic        s_bypass,
    input  logic        s_native_underlay,
    input  logic        s_in_no_ssl_list,
    input  logic [15:0] s_clients_from_address,
    input  logic [15:0] s_unestablished_now,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic        m_entry_removed,
    output logic        m_table_full
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SW_RD  = 4'd1;  // sweep: address the entry
    localparam logic [3:0] ST_SW_CMP = 4'd2;  // sweep: RAM data out
    localparam logic [3:0] ST_SW_ACT = 4'd3;  // sweep: compare registered
    localparam logic [3:0] ST_LK_RD  = 4'd4;
    localparam logic [3:0] ST_LK_CMP = 4'd5;
    localparam logic [3:0] ST_LK_ACT = 4'd6;
    localparam logic [3:0] ST_UPDATE = 4'd7;  // act on the lookup outcome
    localparam logic [3:0] ST_WRITE  = 4'd8;
    localparam logic [3:0] ST_CHECKS = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    pscfg_pkg::cfg_t cfg_reg;

    logic [3:0]  state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [47:0] last_sweep_reg, last_sweep_next;

    // latched item
    logic        cmd_reg;
    logic [63:0] ahi_reg, alo_reg;
    logic [47:0] now_reg;
    logic        native_reg, nossl_reg;
    logic [15:0] clients_reg, pend_reg;

    logic        hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [2:0]  verdict_reg, verdict_next;
    logic        removed_reg, removed_next;
    logic        full_reg, full_next;
    pscfg_pkg::entry_t wentry_reg, wentry_next;

    // RAM port
    logic              ram_we;
    logic [IW-1:0]     ram_addr;
    pscfg_pkg::entry_t ram_rdata;
    logic              stale_q, match_q;

    pscfg_ram #(.WIDTH(pscfg_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wentry_reg),
        .rdata (ram_rdata)
    );

    pscfg_stale_unit u_stale (
        .aclk      (aclk),
        .entry     (ram_rdata),
        .now       (now_reg),
        .addr_high (ahi_reg),
        .addr_low  (alo_reg),
        .stale_reg (stale_q),
        .match_reg (match_q)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_verdict       = verdict_reg;
    assign m_entry_removed = removed_reg;
    assign m_table_full    = full_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.guard_enable        <= 1'b1;
            cfg_reg.first_span          <= 32'd1000;
            cfg_reg.span_cap            <= 32'd60000;
            cfg_reg.entry_lifetime      <= 32'd300000;
            cfg_reg.repeat_limit        <= 16'd32;
            cfg_reg.sweep_interval      <= 32'd1000;
            cfg_reg.per_address_limit   <= 16'd16;
            cfg_reg.unestablished_limit <= 16'd1000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pscfg_pkg::REG_GUARD_ENABLE:   cfg_reg.guard_enable   <= cfg_data[0];
                pscfg_pkg::REG_FIRST_SPAN:     cfg_reg.first_span     <= cfg_data;
                pscfg_pkg::REG_SPAN_CAP:       cfg_reg.span_cap       <= cfg_data;
                pscfg_pkg::REG_ENTRY_LIFETIME: cfg_reg.entry_lifetime <= cfg_data;
                pscfg_pkg::REG_REPEAT_LIMIT:   cfg_reg.repeat_limit   <= cfg_data[15:0];
                pscfg_pkg::REG_SWEEP_INTERVAL: cfg_reg.sweep_interval <= cfg_data;
                pscfg_pkg::REG_PER_ADDR_LIMIT:
                    cfg_reg.per_address_limit <= cfg_data[15:0];
                pscfg_pkg::REG_UNEST_LIMIT:
                    cfg_reg.unestablished_limit <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            ahi_reg     <= s_addr_high;
            alo_reg     <= s_addr_low;
            now_reg     <= s_now;
            native_reg  <= s_native_underlay;
            nossl_reg   <= s_in_no_ssl_list;
            clients_reg <= s_clients_from_address;
            pend_reg    <= s_unestablished_now;
        end
    end

    // sweep-due test: full sum, no wrap
    logic [48:0] sweep_sum;
    logic        sweep_due;
    assign sweep_sum = {1'b0, last_sweep_reg} + {17'd0, cfg_reg.sweep_interval};
    assign sweep_due = (last_sweep_reg == 48'd0) || (sweep_sum <= {1'b0, s_now});

    // entry update arithmetic, only one path active per item
    logic [32:0] span_dbl;
    logic [31:0] span_new;
    logic [15:0] count_new;
    logic [48:0] del_sum;
    logic [47:0] del_new;
    logic [IW-1:0] free_idx;
    logic          free_any;

    always_comb begin
        span_dbl  = {ram_rdata.span, 1'b0};
        span_new  = (span_dbl > {1'b0, cfg_reg.span_cap}) ? cfg_reg.span_cap
                                                         : span_dbl[31:0];
        count_new = (ram_rdata.count == pscfg_pkg::COUNT_MAX) ? ram_rdata.count
                                                              : ram_rdata.count + 16'd1;
        del_sum   = {1'b0, now_reg} + {17'd0, cfg_reg.entry_lifetime};
        del_new   = del_sum[48] ? pscfg_pkg::TIME_MAX : del_sum[47:0];
    end

    // lowest free slot: priority encoder over valid bits
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (!valid_reg[k]) begin
                free_idx = IW'(k);
                free_any = 1'b1;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        last_sweep_next = last_sweep_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        verdict_next    = verdict_reg;
        removed_next    = removed_reg;
        full_next       = full_reg;
        wentry_next     = wentry_reg;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                idx_next     = '0;
                hit_next     = 1'b0;
                verdict_next = pscfg_pkg::VERDICT_ADMIT;
                removed_next = 1'b0;
                full_next    = 1'b0;
                if (s_valid) begin
                    if (!s_cmd && (!cfg_reg.guard_enable || s_bypass)) begin
                        state_next = ST_OUT;
                    end else if (sweep_due) begin
                        last_sweep_next = s_now;
                        state_next      = ST_SW_RD;
                    end else begin
                        state_next = ST_LK_RD;
                    end
                end
            end
            ST_SW_RD:  state_next = ST_SW_CMP;
            ST_SW_CMP: state_next = ST_SW_ACT;
            ST_SW_ACT: begin
                if (valid_reg[idx_reg] && stale_q) begin
                    valid_next[idx_reg] = 1'b0;
                end
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_LK_RD;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_LK_RD:  state_next = ST_LK_CMP;
            ST_LK_CMP: state_next = ST_LK_ACT;
            ST_LK_ACT: begin
                if (valid_reg[idx_reg] && match_q) begin
                    // first match ends the search; a stale one is dropped
                    if (stale_q) begin
                        valid_next[idx_reg] = 1'b0;
                    end else begin
                        hit_next = 1'b1;
                    end
                    hit_idx_next = idx_reg;
                    state_next   = ST_UPDATE;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = ST_UPDATE;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_LK_RD;
                end
            end
            ST_UPDATE: begin
                // RAM still holds the last entry read (the hit, if any)
                ram_addr = hit_idx_reg;
                if (cmd_reg) begin
                    removed_next = hit_reg;
                    if (hit_reg) begin
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                    state_next = ST_OUT;
                end else if (hit_reg) begin
                    wentry_next           = ram_rdata;
                    wentry_next.last_seen = now_reg;
                    wentry_next.span      = span_new;
                    wentry_next.count     = count_new;
                    if (count_new > cfg_reg.repeat_limit) begin
                        verdict_next = pscfg_pkg::VERDICT_REPEAT;
                    end
                    state_next = ST_WRITE;
                end else if (free_any) begin
                    hit_idx_next          = free_idx;
                    valid_next[free_idx]  = 1'b1;
                    wentry_next.addr_high = ahi_reg;
                    wentry_next.addr_low  = alo_reg;
                    wentry_next.last_seen = now_reg;
                    wentry_next.span      = cfg_reg.first_span;
                    wentry_next.count     = 16'd1;
                    wentry_next.delete_at = del_new;
                    state_next            = ST_WRITE;
                end else begin
                    full_next  = 1'b1;
                    state_next = ST_CHECKS;
                end
            end
            ST_WRITE: begin
                ram_we     = 1'b1;
                ram_addr   = hit_idx_reg;
                state_next = ST_CHECKS;
            end
            ST_CHECKS: begin
                if (verdict_reg == pscfg_pkg::VERDICT_ADMIT) begin
                    priority if (native_reg && nossl_reg) begin
                        verdict_next = pscfg_pkg::VERDICT_NO_SSL;
                    end else if (clients_reg > cfg_reg.per_address_limit) begin
                        verdict_next = pscfg_pkg::VERDICT_PER_ADR;
                    end else if (pend_reg > cfg_reg.unestablished_limit) begin
                        verdict_next = pscfg_pkg::VERDICT_UNEST;
                    end else begin
                        verdict_next = pscfg_pkg::VERDICT_ADMIT;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            last_sweep_reg <= '0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            last_sweep_reg <= last_sweep_next;
        end
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        verdict_reg <= verdict_next;
        removed_reg <= removed_next;
        full_reg    <= full_next;
        wentry_reg  <= wentry_next;
    end
endmodule

/* rtl/pscfg_ram.sv */
// ----------------------------------------------------------------------------
// pscfg_ram: generic single-port RAM
// One write and one read of the same address per cycle, registered read data (old word on a write).
// ----------------------------------------------------------------------------
module pscfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/pscfg_stale_unit.sv */
// ----------------------------------------------------------------------------
// pscfg_stale_unit: shared expiry compare
// Registers last_seen + span <= now || delete_at <= now, and address match.
// ----------------------------------------------------------------------------
module pscfg_stale_unit (
    input  logic                          aclk,
    input  pscfg_pkg::entry_t             entry,
    input  logic [pscfg_pkg::TIME_W-1:0]  now,
    input  logic [pscfg_pkg::ADDR_W-1:0]  addr_high,
    input  logic [pscfg_pkg::ADDR_W-1:0]  addr_low,
    output logic                          stale_reg,
    output logic                          match_reg
);
    logic [pscfg_pkg::TIME_W:0] expire_sum;
    logic                       stale_next;
    logic                       match_next;

    always_comb begin
        expire_sum = {1'b0, entry.last_seen}
                   + {{(pscfg_pkg::TIME_W+1-pscfg_pkg::SPAN_W){1'b0}}, entry.span};
        stale_next = (expire_sum <= {1'b0, now}) || (entry.delete_at <= now);
        match_next = (entry.addr_high == addr_high) && (entry.addr_low == addr_low);
    end

    always_ff @(posedge aclk) begin
        stale_reg <= stale_next;
        match_reg <= match_next;
    end
endmodule

/* rtl/pscfg_checker.sv */
// ----------------------------------------------------------------------------
// pscfg_checker: port-level checks for the flood guard
// Watches result codes and handshake behavior at the top-level ports.
// ----------------------------------------------------------------------------
module pscfg_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_verdict,
    input logic       m_entry_removed,
    input logic       m_table_full
);
    // one item in flight: no new item while a result waits
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("item accepted while result pending");

    // a removal never carries a verdict or a full flag
    a_remove_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_entry_removed) |->
            (m_verdict == pscfg_pkg::VERDICT_ADMIT && !m_table_full))
        else $error("remove result carries check outputs");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict <= pscfg_pkg::VERDICT_UNEST))
        else $error("verdict out of range");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_verdict)))
        else $error("result dropped while stalled");
endmodule

bind per_source_connection_flood_guard pscfg_checker u_pscfg_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_verdict       (m_verdict),
    .m_entry_removed (m_entry_removed),
    .m_table_full    (m_table_full)
);
